>>> rtl/wildcard_grab_match_table_defines.svh
// ----------------------------------------------------------------------------
// wildcard_grab_match_table_defines
// Assertion macros for the grab match table.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_GRAB_MATCH_TABLE_DEFINES_SVH
`define WILDCARD_GRAB_MATCH_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define WGMT_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define WGMT_ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define WGMT_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define WGMT_ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

>>> rtl/wgmt_pkg.sv
// ----------------------------------------------------------------------------
// wgmt_pkg
// Types and codes shared by the grab match table modules.
// ----------------------------------------------------------------------------
package wgmt_pkg;

  localparam int DEFAULT_DEPTH = 16;

  localparam logic [2:0] KIND_INSERT    = 3'd0;
  localparam logic [2:0] KIND_REMOVE_WC = 3'd1;
  localparam logic [2:0] KIND_MATCH     = 3'd2;
  localparam logic [2:0] KIND_REMOVE_WIN = 3'd3;
  localparam logic [2:0] KIND_REMOVE_OWN = 3'd4;
  localparam logic [2:0] KIND_CLEAR     = 3'd5;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_NOMATCH = 2'd2;

  localparam logic CFG_WC_BUTTON = 1'b0;
  localparam logic CFG_WC_MODS   = 1'b1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] window;
    logic [7:0]  button;
    logic [15:0] modifiers;
    logic [15:0] owner;
    logic [31:0] payload;
  } wgmt_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [7:0]  hit_button;
    logic [15:0] hit_modifiers;
    logic [15:0] hit_owner;
    logic [31:0] hit_payload;
  } wgmt_out_t;

endpackage

>>> rtl/wgmt_front.sv
// ----------------------------------------------------------------------------
// wgmt_front
// Accepts request words and holds them in a two-entry queue for the scanner.
// ----------------------------------------------------------------------------
module wgmt_front import wgmt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  wgmt_in_t in_word,
  output logic     req_valid,
  input  logic     req_take,
  output wgmt_in_t req_word
);

  wgmt_in_t   q_r [2];
  logic       rd_r, wr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full      = cnt_r[1];
  assign req_valid = (cnt_r != 2'd0);
  assign req_word  = q_r[rd_r];
  assign do_push   = push && !full;
  assign do_pop    = req_take && req_valid;

  // Queue storage: payload needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_r] <= in_word;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wr_r <= ~wr_r;
      if (do_pop)  rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

>>> rtl/wgmt_back.sv
// ----------------------------------------------------------------------------
// wgmt_back
// Scans the table one entry per cycle, carries out the request and queues
// the result word.
// ----------------------------------------------------------------------------
`include "wildcard_grab_match_table_defines.svh"
module wgmt_back import wgmt_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      req_valid,
  output logic      req_take,
  input  wgmt_in_t  req_word,
  input  logic [7:0]  wc_button,
  input  logic [15:0] wc_mods,
  output logic      empty,
  input  logic      pop,
  output wgmt_out_t out_word
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]  st_r, st_nxt;
  logic [IW-1:0] idx_r, rd_addr;
  wgmt_in_t    cur_r;
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [31:0] win_m  [TABLE_DEPTH];
  logic [7:0]  btn_m  [TABLE_DEPTH];
  logic [15:0] mods_m [TABLE_DEPTH];
  logic [15:0] own_m  [TABLE_DEPTH];
  logic [31:0] pay_m  [TABLE_DEPTH];

  // Fields of the entry under the scan pointer are read in the cycle before
  // into registers; the matched entry is read once after the scan.
  logic [31:0] e_win_r;
  logic [7:0]  e_btn_r;
  logic [15:0] e_mods_r, e_own_r;
  logic        e_val;
  logic        found_r, free_found_r;
  logic [IW-1:0] slot_r, free_r;
  logic [1:0]  best_r;
  logic [IW-1:0] best_idx_r;
  logic        res_full_r;
  wgmt_out_t   res_r, res_nxt;
  logic [31:0] rd_pay_r;
  logic [15:0] rd_own_r;
  logic [7:0]  rd_btn_r;
  logic [15:0] rd_mods_r;

  logic key_eq, bwild, mwild, m_ok, anyb, anym, scan_go;
  logic [1:0] score;

  assign e_val  = valid_r[idx_r];

  // Next address to fetch: entry 0 outside the scan and at its last entry, the following entry otherwise.
  assign rd_addr = (st_r == ST_SCAN && idx_r != LAST) ? idx_r + 1'b1 : '0;

  assign key_eq = e_win_r == cur_r.window && e_btn_r == cur_r.button &&
                  e_mods_r == cur_r.modifiers;
  assign bwild  = e_btn_r == wc_button;
  assign mwild  = e_mods_r == wc_mods;
  assign m_ok   = e_val && e_win_r == cur_r.window && (bwild || e_btn_r == cur_r.button) &&
                  (mwild || e_mods_r == cur_r.modifiers);
  assign score  = {!bwild, !mwild};
  assign anyb   = cur_r.button == wc_button;
  assign anym   = cur_r.modifiers == wc_mods;
  assign scan_go = (st_r == ST_IDLE) && req_valid && !res_full_r;

  assign req_take = (st_r == ST_IDLE) && !res_full_r;
  assign empty    = !res_full_r;
  assign out_word = res_r;

  // Sequencer: idle, scan, read back matched entry, write back.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (req_valid && !res_full_r) st_nxt = ST_SCAN;
      ST_SCAN: if (idx_r == LAST) st_nxt = ST_RD;
      ST_RD:   st_nxt = ST_DONE;
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Result word built from the scan outcome and the read-back fields.
  always_comb begin
    res_nxt = '0;
    if (cur_r.kind == KIND_INSERT) begin
      if (!(found_r || free_found_r)) res_nxt.status = STATUS_FULL;
    end else if (cur_r.kind == KIND_MATCH) begin
      if (found_r) begin
        res_nxt.hit           = 1'b1;
        res_nxt.hit_button    = rd_btn_r;
        res_nxt.hit_modifiers = rd_mods_r;
        res_nxt.hit_owner     = rd_own_r;
        res_nxt.hit_payload   = rd_pay_r;
      end else begin
        res_nxt.status = STATUS_NOMATCH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      valid_r    <= '0;
      res_full_r <= 1'b0;
      idx_r      <= '0;
    end else begin
      st_r <= st_nxt;
      if (pop && res_full_r) res_full_r <= 1'b0;
      if (scan_go) idx_r <= '0;
      // Scan step: removals take effect per entry as it is visited.
      if (st_r == ST_SCAN) begin
        if (idx_r != LAST) idx_r <= idx_r + 1'b1;
        case (cur_r.kind)
          KIND_REMOVE_WC:
            if (e_val && e_win_r == cur_r.window && (anyb || e_btn_r == cur_r.button) &&
                (anym || e_mods_r == cur_r.modifiers)) valid_r[idx_r] <= 1'b0;
          KIND_REMOVE_WIN:
            if (e_val && e_win_r == cur_r.window) valid_r[idx_r] <= 1'b0;
          KIND_REMOVE_OWN:
            if (e_val && e_own_r == cur_r.owner) valid_r[idx_r] <= 1'b0;
          KIND_CLEAR: valid_r[idx_r] <= 1'b0;
          default: ;
        endcase
      end
      if (st_r == ST_DONE) begin
        res_full_r <= 1'b1;
        if (cur_r.kind == KIND_INSERT && (found_r || free_found_r))
          valid_r[found_r ? slot_r : free_r] <= 1'b1;
      end
    end
  end

  // Entry fetch for the scan.
  always_ff @(posedge clk) begin
    e_win_r  <= win_m[rd_addr];
    e_btn_r  <= btn_m[rd_addr];
    e_mods_r <= mods_m[rd_addr];
    e_own_r  <= own_m[rd_addr];
  end

  // Scan bookkeeping and entry writes.
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE) begin
      cur_r        <= req_word;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      best_r       <= 2'd0;
    end
    if (st_r == ST_SCAN) begin
      if (cur_r.kind == KIND_INSERT) begin
        if (e_val && key_eq && !found_r) begin
          found_r <= 1'b1;
          slot_r  <= idx_r;
        end else if (!e_val && !free_found_r) begin
          free_found_r <= 1'b1;
          free_r       <= idx_r;
        end
      end else if (m_ok && (!found_r || score > best_r)) begin
        found_r    <= 1'b1;
        best_r     <= score;
        best_idx_r <= idx_r;
      end
    end
    if (st_r == ST_RD) begin
      rd_pay_r  <= pay_m[best_idx_r];
      rd_own_r  <= own_m[best_idx_r];
      rd_btn_r  <= btn_m[best_idx_r];
      rd_mods_r <= mods_m[best_idx_r];
    end
    if (st_r == ST_DONE) begin
      res_r <= res_nxt;
      if (cur_r.kind == KIND_INSERT && (found_r || free_found_r)) begin
        win_m[found_r ? slot_r : free_r]  <= cur_r.window;
        btn_m[found_r ? slot_r : free_r]  <= cur_r.button;
        mods_m[found_r ? slot_r : free_r] <= cur_r.modifiers;
        own_m[found_r ? slot_r : free_r]  <= cur_r.owner;
        pay_m[found_r ? slot_r : free_r]  <= cur_r.payload;
      end
    end
  end

  `WGMT_ASSERT_IMPL(a_take_idle, clk, rst_n, req_take |-> st_r == ST_IDLE, "take outside idle")
  `WGMT_ASSERT_NEVER(a_done_full, clk, rst_n, st_r == ST_DONE && res_full_r, "result overrun")
  `WGMT_ASSERT_IMPL(a_scan_start, clk, rst_n, scan_go |=> idx_r == '0, "scan start")

endmodule

>>> rtl/wildcard_grab_match_table.sv
// ----------------------------------------------------------------------------
// wildcard_grab_match_table
// Passive grab table with wildcard matching and most-specific lookup.
// ----------------------------------------------------------------------------
// Channel  Ports                        Handshake
// in       in_word, push, full          push && !full
// out      out_word, pop, empty         pop && !empty
// cfg      cfg_index, cfg_data          cfg_valid && cfg_ready
// Every request takes one scan step per entry in the back end, plus load,
// read-back and write-back steps.
// Reset clears all valid bits at once; entry contents are left as they are.
// A waiting result word stalls the back end; the front queue holds two words.
module wildcard_grab_match_table import wgmt_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  wgmt_in_t    in_word,
  output logic        empty,
  input  logic        pop,
  output wgmt_out_t   out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0]  wc_button_r;
  logic [15:0] wc_mods_r;
  logic        req_valid, req_take;
  wgmt_in_t    req_word;

  assign cfg_ready = 1'b1;

  // Wildcard code registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_button_r <= 8'd0;
      wc_mods_r   <= 16'd32768;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_WC_BUTTON) wc_button_r <= cfg_data[7:0];
      else wc_mods_r <= cfg_data;
    end
  end

  wgmt_front u_front (
    .clk, .rst_n, .push, .full, .in_word,
    .req_valid, .req_take, .req_word
  );

  wgmt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk, .rst_n, .req_valid, .req_take, .req_word,
    .wc_button(wc_button_r), .wc_mods(wc_mods_r),
    .empty, .pop, .out_word
  );

endmodule
